// ===== src/tfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfsm_pkg: shared definitions for the thresholded force and speed mean block
// Field widths, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
package tfsm_pkg;

  // Fixed field widths.
  localparam int FORCE_W    = 24;
  localparam int THRESH_W   = 24;
  localparam int PERIOD_W   = 20;
  localparam int FSUM_W     = 45;
  localparam int DSUM_W     = 46;
  localparam int MEANF_W    = 24;
  localparam int MEANV_W    = 32;
  localparam int ACNT_W     = 20;
  localparam int QUO_W      = 32;

  // Microseconds per second, the scale that turns um per sample into um/s.
  localparam int                USEC_W     = 20;
  localparam logic [USEC_W-1:0] USEC_PER_S = 20'd1000000;

  // Default values of the top-level parameters.
  localparam int COUNT_BITS_DEF = 20;
  localparam int COORD_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RST = 24'd10000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd2000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_ACC,
    ST_END,
    ST_MUL,
    ST_DIV_F,
    ST_DIV_V,
    ST_FIN
  } tfsm_state_e;

endpackage

// ===== src/tfsm_sqsum.sv =====
// ----------------------------------------------------------------------------
// tfsm_sqsum: bit-serial sum of three squares
// Three shift-add lanes share one accumulator; one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tfsm_sqsum #(
  parameter int W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic [W-1:0]     c_i,
  output logic             busy_o,
  output logic [2*W+1:0]   sum_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_q, b_q, c_q;
  logic [W-1:0]  am_q, bm_q, cm_q;
  logic [W+1:0]  hi_q;
  logic [W-1:0]  lo_q;
  logic [CW-1:0] cnt_q;
  logic [W+1:0]  pa, pb, pc, addend;
  logic [W+2:0]  acc;

  // Each lane adds its multiplicand when the current multiplier bit is set.
  always_comb begin
    pa     = am_q[0] ? {2'b00, a_q} : '0;
    pb     = bm_q[0] ? {2'b00, b_q} : '0;
    pc     = cm_q[0] ? {2'b00, c_q} : '0;
    addend = pa + pb + pc;
    acc    = {1'b0, hi_q} + {1'b0, addend};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      c_q  <= c_i;
      am_q <= a_i;
      bm_q <= b_i;
      cm_q <= c_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (cnt_q != '0) begin
      am_q <= am_q >> 1;
      bm_q <= bm_q >> 1;
      cm_q <= cm_q >> 1;
      hi_q <= acc[W+2:1];
      lo_q <= {acc[0], lo_q[W-1:1]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign sum_o  = {hi_q, lo_q};

endmodule

// ===== src/tfsm_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfsm_sqrt: digit-serial integer square root
// Restoring method, one root bit per cycle from two radicand bits.
// ----------------------------------------------------------------------------
module tfsm_sqrt #(
  parameter int IW = 50
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IW-1:0]   rad_i,
  output logic            busy_o,
  output logic [IW/2-1:0] root_o,
  output logic            rem_nz_o
);

  localparam int RW = IW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [IW-1:0] rad_q;
  logic [RW-1:0] root_q;
  logic [RW:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic [RW+2:0] cand, trial, diff;
  logic          ge;

  always_comb begin
    cand  = {rem_q, rad_q[IW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (cand >= trial);
    diff  = cand - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(RW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // The remainder never exceeds twice the partial root, so it fits RW+1 bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[IW-3:0], 2'b00};
      root_q <= {root_q[RW-2:0], ge};
      rem_q  <= ge ? diff[RW:0] : cand[RW:0];
    end
  end

  assign busy_o   = (cnt_q != '0);
  assign root_o   = root_q;
  assign rem_nz_o = (rem_q != '0);

endmodule

// ===== src/tfsm_mul.sv =====
// ----------------------------------------------------------------------------
// tfsm_mul: bit-serial unsigned multiplier
// Shift-add with a stationary multiplicand, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tfsm_mul #(
  parameter int AW = 20,
  parameter int BW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [AW-1:0] hi_q;
  logic [BW-1:0] lo_q;
  logic [CW-1:0] cnt_q;
  logic [AW:0]   acc;

  assign acc = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(BW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (cnt_q != '0) begin
      b_q  <= b_q >> 1;
      hi_q <= acc[AW:1];
      lo_q <= {acc[0], lo_q[BW-1:1]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== src/tfsm_div.sv =====
// ----------------------------------------------------------------------------
// tfsm_div: bit-serial restoring divider
// One quotient bit per cycle; keeps the low quotient bits and a sticky flag
// for any set bit above them.
// ----------------------------------------------------------------------------
module tfsm_div
  import tfsm_pkg::*;
#(
  parameter int NW = 66,
  parameter int DW = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             quo_ovf_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    num_q;
  logic [DW-1:0]    den_q;
  logic [DW-1:0]    rem_q;
  logic [QUO_W-1:0] quo_q;
  logic             ovf_q;
  logic [CW-1:0]    cnt_q;
  logic [DW:0]      cand, diff;
  logic             ge;

  always_comb begin
    cand = {rem_q, num_q[NW-1]};
    ge   = (cand >= {1'b0, den_q});
    diff = cand - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= ge ? diff[DW-1:0] : cand[DW-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[QUO_W-1];
    end
  end

  assign busy_o    = (cnt_q != '0);
  assign quo_o     = quo_q;
  assign quo_ovf_o = ovf_q;

endmodule

// ===== src/thresholded_force_speed_mean.sv =====
// ----------------------------------------------------------------------------
// thresholded_force_speed_mean: mean force and speed over a robot path run
// Counts samples whose force magnitude exceeds a threshold and reports the
// mean force and mean speed of those samples when a run ends.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   -------  ---------  ------------------------  -----------------------------
//   cfg      in         cfg_we_i (write enable)   cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_ready_o   pos_x/y/z_i, force_x/y/z_i,
//                                                 last_sample_i
//   out      out        out_valid_o / out_ready_i mean_force_o, mean_velocity_o,
//                                                 accepted_count_o, overflow_o
//
// An ordinary item runs through the bit-serial squaring lanes and then the
// digit-serial square roots before the next item is accepted. The item that
// ends a run then also passes the serial multipliers, which form the divisor
// and the scaled distance, and one shared 66-step divider that runs twice.
// Reset puts both registers at their documented values and clears the run.
// A finished result waits in an output register; new items are accepted
// meanwhile, and only the next end of run stalls until that result is taken.
//
// ----------------------------------------------------------------------------
module thresholded_force_speed_mean
  import tfsm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  // Sample input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic signed [FORCE_W-1:0]    force_x_i,
  input  logic signed [FORCE_W-1:0]    force_y_i,
  input  logic signed [FORCE_W-1:0]    force_z_i,
  input  logic                         last_sample_i,
  // Result output channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [MEANF_W-1:0]           mean_force_o,
  output logic [MEANV_W-1:0]           mean_velocity_o,
  output logic [ACNT_W-1:0]            accepted_count_o,
  output logic                         overflow_o
);

  // The squared force magnitude has 2*24+2 bits and its root 25 bits; the
  // squared distance has 2*COORD_BITS+2 bits and its root COORD_BITS+1 bits.
  localparam int FMAG_IW = 2 * FORCE_W + 2;
  localparam int FMAG_RW = FORCE_W + 1;
  localparam int DIST_IW = 2 * COORD_BITS + 2;
  localparam int DIST_RW = COORD_BITS + 1;
  // The divisor is period times count; the dividend is distance times 10^6.
  localparam int DEN_W   = PERIOD_W + COUNT_BITS;
  localparam int NUM_W   = DSUM_W + USEC_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Magnitude of a two's complement force component.
  function automatic logic [FORCE_W-1:0] abs_force(input logic [FORCE_W-1:0] f);
    abs_force = f[FORCE_W-1] ? (~f + FORCE_W'(1)) : f;
  endfunction

  // Distance along one axis. Both differences are formed side by side and
  // the sign of the forward one picks the non-negative result.
  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] fwd;
    logic [COORD_BITS:0] bwd;
    fwd = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    bwd = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
    abs_diff = fwd[COORD_BITS] ? bwd[COORD_BITS-1:0] : fwd[COORD_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  tfsm_state_e state_q, state_d;

  logic [THRESH_W-1:0]   thresh_q;
  logic [PERIOD_W-1:0]   period_q;

  // Current sample, held while it is being processed.
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                  last_q;

  // Run state.
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [COORD_BITS-1:0] prev_x_d, prev_y_d, prev_z_d;
  logic [FSUM_W-1:0]     fsum_q, fsum_d;
  logic [DSUM_W-1:0]     dsum_q, dsum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  sat_q, sat_d;

  // Means of the run being closed.
  logic [MEANF_W-1:0]    mf_q, mf_d;
  logic [MEANV_W-1:0]    mv_q, mv_d;

  // Output register.
  logic                  out_valid_q;
  logic [MEANF_W-1:0]    out_mf_q;
  logic [MEANV_W-1:0]    out_mv_q;
  logic [ACNT_W-1:0]     out_cnt_q;
  logic                  out_ovf_q;

  // --------------------------------------------------------------------------
  // Datapath signals
  // --------------------------------------------------------------------------
  logic                  in_accept;
  logic                  sqrt_start, mul_start, div_start, fin_go;
  logic                  fsq_busy, dsq_busy, fsqrt_busy, dsqrt_busy;
  logic                  den_busy, num_busy, div_busy;
  logic [FMAG_IW-1:0]    fsq_sum;
  logic [DIST_IW-1:0]    dsq_sum;
  logic [FMAG_RW-1:0]    fmag;
  logic                  frem_nz;
  logic [DIST_RW-1:0]    step_len;
  logic                  hit;
  logic [FSUM_W:0]       fsum_add;
  logic [DSUM_W:0]       dsum_add;
  logic [PERIOD_W-1:0]   per_eff;
  logic [DEN_W-1:0]      den_prod;
  logic [NUM_W-1:0]      num_prod;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [QUO_W-1:0]      div_quo;
  logic                  div_ovf;
  logic [COUNT_BITS+ACNT_W-1:0] cnt_wide;
  logic [ACNT_W-1:0]     cnt_cap;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORCE_THRESHOLD: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        REG_SAMPLE_PERIOD:   period_q <= cfg_wdata_i[PERIOD_W-1:0];
        default:             ;
      endcase
    end
  end

  // A zero period would make the divisor vanish, so it counts as one.
  assign per_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  // --------------------------------------------------------------------------
  // Squaring lanes and square roots. Both magnitudes are worked out for every
  // sample; the threshold decision uses the force root and its remainder.
  // --------------------------------------------------------------------------
  tfsm_sqsum #(.W(FORCE_W)) u_fsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .a_i     (abs_force(force_x_i)),
    .b_i     (abs_force(force_y_i)),
    .c_i     (abs_force(force_z_i)),
    .busy_o  (fsq_busy),
    .sum_o   (fsq_sum)
  );

  tfsm_sqsum #(.W(COORD_BITS)) u_dsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .a_i     (abs_diff(pos_x_i, prev_x_q)),
    .b_i     (abs_diff(pos_y_i, prev_y_q)),
    .c_i     (abs_diff(pos_z_i, prev_z_q)),
    .busy_o  (dsq_busy),
    .sum_o   (dsq_sum)
  );

  tfsm_sqrt #(.IW(FMAG_IW)) u_fsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .rad_i    (fsq_sum),
    .busy_o   (fsqrt_busy),
    .root_o   (fmag),
    .rem_nz_o (frem_nz)
  );

  tfsm_sqrt #(.IW(DIST_IW)) u_dsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .rad_i    (dsq_sum),
    .busy_o   (dsqrt_busy),
    .root_o   (step_len),
    .rem_nz_o ()
  );

  // The magnitude exceeds the threshold exactly when the integer root is
  // larger, or equal with a nonzero remainder.
  assign hit = (fmag > {1'b0, thresh_q}) || ((fmag == {1'b0, thresh_q}) && frem_nz);

  // A carry out of the sum width means the sum saturates.
  assign fsum_add = {1'b0, fsum_q} + (FSUM_W + 1)'(fmag);
  assign dsum_add = {1'b0, dsum_q} + (DSUM_W + 1)'(step_len);

  // --------------------------------------------------------------------------
  // End-of-run arithmetic: serial multipliers, then one shared divider that
  // first yields the mean force and then the mean speed.
  // --------------------------------------------------------------------------
  tfsm_mul #(.AW(PERIOD_W), .BW(COUNT_BITS)) u_den_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (per_eff),
    .b_i     (count_q),
    .busy_o  (den_busy),
    .prod_o  (den_prod)
  );

  tfsm_mul #(.AW(DSUM_W), .BW(USEC_W)) u_num_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (dsum_q),
    .b_i     (USEC_PER_S),
    .busy_o  (num_busy),
    .prod_o  (num_prod)
  );

  // While the force quotient is running the speed operands are selected, so
  // they are in place when the second division starts.
  always_comb begin
    if (state_q == ST_DIV_F) begin
      div_num = num_prod;
      div_den = den_prod;
    end else begin
      div_num = NUM_W'(fsum_q);
      div_den = DEN_W'(count_q);
    end
  end

  tfsm_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (div_num),
    .den_i     (div_den),
    .busy_o    (div_busy),
    .quo_o     (div_quo),
    .quo_ovf_o (div_ovf)
  );

  // The reported count is capped at the width of the output field.
  always_comb begin
    cnt_wide = {{ACNT_W{1'b0}}, count_q};
    if (cnt_wide > (COUNT_BITS + ACNT_W)'({ACNT_W{1'b1}})) begin
      cnt_cap = {ACNT_W{1'b1}};
    end else begin
      cnt_cap = cnt_wide[ACNT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    fin_go     = 1'b0;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    prev_z_d   = prev_z_q;
    fsum_d     = fsum_q;
    dsum_d     = dsum_q;
    count_d    = count_q;
    sat_d      = sat_q;
    mf_d       = mf_q;
    mv_d       = mv_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SQ;
        end
      end

      ST_SQ: begin
        if (!fsq_busy && !dsq_busy) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end

      ST_ROOT: begin
        if (!fsqrt_busy && !dsqrt_busy) begin
          state_d = ST_ACC;
        end
      end

      // A counted sample adds to both sums and becomes the previous position.
      // At full count the count holds but the sums still move.
      ST_ACC: begin
        if (hit) begin
          if (fsum_add[FSUM_W]) begin
            fsum_d = '1;
            sat_d  = 1'b1;
          end else begin
            fsum_d = fsum_add[FSUM_W-1:0];
          end
          if (dsum_add[DSUM_W]) begin
            dsum_d = '1;
            sat_d  = 1'b1;
          end else begin
            dsum_d = dsum_add[DSUM_W-1:0];
          end
          if (count_q == CNT_MAX) begin
            sat_d = 1'b1;
          end else begin
            count_d = count_q + COUNT_BITS'(1);
          end
          prev_x_d = pos_x_q;
          prev_y_d = pos_y_q;
          prev_z_d = pos_z_q;
        end
        state_d = last_q ? ST_END : ST_IDLE;
      end

      // With no counted sample both means are zero and no division runs.
      ST_END: begin
        if (count_q == '0) begin
          mf_d    = '0;
          mv_d    = '0;
          state_d = ST_FIN;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end

      ST_MUL: begin
        if (!den_busy && !num_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV_F;
        end
      end

      ST_DIV_F: begin
        if (!div_busy) begin
          if (div_ovf || (div_quo[QUO_W-1:MEANF_W] != '0)) begin
            mf_d = '1;
          end else begin
            mf_d = div_quo[MEANF_W-1:0];
          end
          div_start = 1'b1;
          state_d   = ST_DIV_V;
        end
      end

      ST_DIV_V: begin
        if (!div_busy) begin
          mv_d    = div_ovf ? '1 : div_quo;
          state_d = ST_FIN;
        end
      end

      // Hand the result to the output register once it is free, then start
      // a new run from the origin.
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          fin_go   = 1'b1;
          prev_x_d = '0;
          prev_y_d = '0;
          prev_z_d = '0;
          fsum_d   = '0;
          dsum_d   = '0;
          count_d  = '0;
          sat_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
      fsum_q   <= '0;
      dsum_q   <= '0;
      count_q  <= '0;
      sat_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      prev_z_q <= prev_z_d;
      fsum_q   <= fsum_d;
      dsum_q   <= dsum_d;
      count_q  <= count_d;
      sat_q    <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      last_q  <= last_sample_i;
    end
    mf_q <= mf_d;
    mv_q <= mv_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_mf_q  <= mf_q;
      out_mv_q  <= mv_q;
      out_cnt_q <= cnt_cap;
      out_ovf_q <= sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mean_force_o     = out_mf_q;
  assign mean_velocity_o  = out_mv_q;
  assign accepted_count_o = out_cnt_q;
  assign overflow_o       = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The roots are complete before the sample is folded into the run.
  a_roots_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> !fsqrt_busy && !dsqrt_busy)
    else $error("sample accumulated while a square root is still running");

  // Every division is started with a nonzero divisor.
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_den != '0)
    else $error("division started with a zero divisor");

  // A result that waits for the consumer is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !fin_go)
    else $error("pending result overwritten");

  // Closing a run leaves the run state cleared.
  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> count_q == '0 && fsum_q == '0 && dsum_q == '0 && !sat_q)
    else $error("run state not cleared after a result");

endmodule

// ===== tb/sv/thresholded_force_speed_mean_tb.sv =====
// ----------------------------------------------------------------------------
// thresholded_force_speed_mean_tb: self-checking bench for the mean block
// Drives path samples through the valid/ready input, predicts each end-of-run
// result in a cycle-free model of the accumulator and checks every field of
// every result, across several register settings and handshake patterns.
// ----------------------------------------------------------------------------
module thresholded_force_speed_mean_tb;
  import tfsm_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int HOLD_CYCLES   = 3000;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 300;      // covers an ordinary item plus a run end
  localparam int CYCLE_LIMIT   = 1000000;

  localparam longint unsigned FSUM_LIMIT  = (64'd1 << FSUM_W) - 1;
  localparam longint unsigned DSUM_LIMIT  = (64'd1 << DSUM_W) - 1;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 1;

  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;

  // One path sample as it travels on the input channel.
  typedef struct {
    logic signed [CW-1:0]      px, py, pz;
    logic signed [FORCE_W-1:0] fx, fy, fz;
    logic                      last;
  } path_sample_t;

  // One end-of-run result.
  typedef struct {
    logic [MEANF_W-1:0] avg_force;
    logic [MEANV_W-1:0] avg_speed;
    logic [ACNT_W-1:0]  accepted_count;
    logic               overflow;
  } run_means_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic signed [CW-1:0]      pos_x_i       = '0;
  logic signed [CW-1:0]      pos_y_i       = '0;
  logic signed [CW-1:0]      pos_z_i       = '0;
  logic signed [FORCE_W-1:0] force_x_i     = '0;
  logic signed [FORCE_W-1:0] force_y_i     = '0;
  logic signed [FORCE_W-1:0] force_z_i     = '0;
  logic                      last_sample_i = 1'b0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [MEANF_W-1:0] mean_force_o;
  logic [MEANV_W-1:0] mean_velocity_o;
  logic [ACNT_W-1:0]  accepted_count_o;
  logic               overflow_o;

  thresholded_force_speed_mean i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Samples waiting to be offered, and the results that finished runs owe us.
  path_sample_t pending_samples[$];
  run_means_t   expected_means[$];
  path_sample_t offered;

  // Handshake pressure knobs, changed only at a falling edge between phases.
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_done      = 1'b0;
  int   hold_count     = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Our copy of the registers; they only change while the block is idle.
  longint unsigned cfg_threshold = THRESH_RST;
  longint unsigned cfg_period    = PERIOD_RST;

  // Run state of the prediction.
  longint          run_prev_x = 0, run_prev_y = 0, run_prev_z = 0;
  longint unsigned run_force_sum = 0, run_dist_sum = 0, run_count = 0;
  logic            run_saturated = 1'b0;

  // Random walk that gives consecutive samples a realistic path.
  logic signed [CW-1:0] walk_x = '0, walk_y = '0, walk_z = '0;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Appends one sample to the end of the pending queue.
  function automatic void enqueue_sample(path_sample_t s);
    pending_samples = {pending_samples, s};
  endfunction

  // Floor of the square root; every argument here is below 2^50.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Folds one accepted sample into the run and, on the last sample of a run,
  // queues the means that the block must report.
  function automatic void fold_sample(path_sample_t s);
    longint          fx, fy, fz, dx, dy, dz;
    longint unsigned fsq, dsq, mag, step_len, den, q;
    logic [127:0]    scaled, vq;
    run_means_t      r;
    fx = s.fx; fy = s.fy; fz = s.fz;
    if (fx < 0) fx = -fx;
    if (fy < 0) fy = -fy;
    if (fz < 0) fz = -fz;
    fsq = fx * fx + fy * fy + fz * fz;
    // Comparing squares keeps the threshold test exact.
    if (fsq > cfg_threshold * cfg_threshold) begin
      mag = int_sqrt(fsq);
      dx = s.px; dy = s.py; dz = s.pz;
      dx -= run_prev_x; dy -= run_prev_y; dz -= run_prev_z;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      dsq      = dx * dx + dy * dy + dz * dz;
      step_len = int_sqrt(dsq);
      if (FSUM_LIMIT - run_force_sum < mag) begin
        run_force_sum = FSUM_LIMIT;
        run_saturated = 1'b1;
      end else begin
        run_force_sum += mag;
      end
      if (DSUM_LIMIT - run_dist_sum < step_len) begin
        run_dist_sum  = DSUM_LIMIT;
        run_saturated = 1'b1;
      end else begin
        run_dist_sum += step_len;
      end
      // A saturated count holds, but the sums and the position still move.
      if (run_count >= COUNT_LIMIT) begin
        run_count     = COUNT_LIMIT;
        run_saturated = 1'b1;
      end else begin
        run_count++;
      end
      run_prev_x = s.px; run_prev_y = s.py; run_prev_z = s.pz;
    end
    if (!s.last) return;
    r.avg_force = '0;
    r.avg_speed = '0;
    if (run_count != 0) begin
      q = run_force_sum / run_count;
      r.avg_force = (q > 64'hFFFFFF) ? '1 : q[MEANF_W-1:0];
      // A zero period counts as one microsecond.
      den    = ((cfg_period == 0) ? 64'd1 : cfg_period) * run_count;
      scaled = {64'd0, run_dist_sum} * 128'd1000000;
      vq     = scaled / {64'd0, den};
      r.avg_speed = (vq > 128'hFFFFFFFF) ? '1 : vq[MEANV_W-1:0];
    end
    r.accepted_count = (run_count > 64'hFFFFF) ? '1 : run_count[ACNT_W-1:0];
    r.overflow       = run_saturated;
    expected_means = {expected_means, r};
    run_prev_x = 0; run_prev_y = 0; run_prev_z = 0;
    run_force_sum = 0; run_dist_sum = 0; run_count = 0;
    run_saturated = 1'b0;
  endfunction

  function automatic path_sample_t path_point(int px, int py, int pz,
                                              int fx, int fy, int fz, bit last);
    path_sample_t s;
    s.px = px; s.py = py; s.pz = pz;
    s.fx = fx; s.fy = fy; s.fz = fz;
    s.last = last;
    return s;
  endfunction

  // Random sample: forces are tiny, close to the threshold on one axis, or
  // anywhere in range; positions mostly walk, sometimes jump anywhere.
  function automatic path_sample_t rand_sample(bit last);
    path_sample_t         s;
    logic signed [FORCE_W-1:0] near;
    int                   mode;
    mode = $urandom_range(9);
    if (mode < 2) begin
      s.fx = $urandom_range(0, 31) - 16;
      s.fy = $urandom_range(0, 31) - 16;
      s.fz = $urandom_range(0, 31) - 16;
    end else if (mode < 4 && cfg_threshold < 64'h7FFFF0) begin
      near = cfg_threshold + $urandom_range(0, 4) - 2;
      if ($urandom_range(1)) near = -near;
      s.fx = '0; s.fy = '0; s.fz = '0;
      case ($urandom_range(2))
        0:       s.fx = near;
        1:       s.fy = near;
        default: s.fz = near;
      endcase
    end else begin
      s.fx = $urandom(); s.fy = $urandom(); s.fz = $urandom();
    end
    if ($urandom_range(9) < 7) begin
      s.px = walk_x + $urandom_range(0, 4000) - 2000;
      s.py = walk_y + $urandom_range(0, 4000) - 2000;
      s.pz = walk_z + $urandom_range(0, 4000) - 2000;
    end else begin
      s.px = $urandom(); s.py = $urandom(); s.pz = $urandom();
    end
    walk_x = s.px; walk_y = s.py; walk_z = s.pz;
    s.last = last;
    return s;
  endfunction

  // Queues whole runs of random length; a few runs are long.
  task automatic queue_random_runs(int n);
    int queued, len;
    queued = 0;
    while (queued < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) enqueue_sample(rand_sample(i == len - 1));
      queued += len;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FORCE_THRESHOLD) cfg_threshold = data[THRESH_W-1:0];
    else                            cfg_period    = data[PERIOD_W-1:0];
  endtask

  // Knobs and queue fills happen at a falling edge, away from the sampling edge.
  task automatic begin_phase(int idle_pct, int stall_pct);
    @(negedge clk_i);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
  endtask

  // Waits until every sample is taken and every result is back, then lets an
  // ordinary item and a run end finish, since a trailing sample with no last
  // flag gives no result to wait for. The queues are looked at on the falling
  // edge, once the driver and the monitor are done with the rising one.
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_means.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sample driver. The prediction is fed at the edge that accepts the item,
  // and the next item goes out only once the current one is gone.
  always @(posedge clk_i) begin : sample_driver
    path_sample_t next_s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) fold_sample(offered);
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_s = pending_samples.pop_front();
          offered       <= next_s;
          in_valid_i    <= 1'b1;
          pos_x_i       <= next_s.px;
          pos_y_i       <= next_s.py;
          pos_z_i       <= next_s.pz;
          force_x_i     <= next_s.fx;
          force_y_i     <= next_s.fy;
          force_z_i     <= next_s.fz;
          last_sample_i <= next_s.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver. Once asked, it refuses results for a long stretch so that
  // the output register fills and the block has to stall its input.
  always @(posedge clk_i) begin : result_sink
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Every taken result is compared with the oldest expected one.
  always @(posedge clk_i) begin : result_monitor
    run_means_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_means.size() == 0) begin
        report_mismatch("result arrived with no finished run pending");
      end else begin
        want = expected_means.pop_front();
        if (mean_force_o !== want.avg_force)
          report_mismatch($sformatf("mean_force_o %0d, expected %0d",
                                    mean_force_o, want.avg_force));
        if (mean_velocity_o !== want.avg_speed)
          report_mismatch($sformatf("mean_velocity_o %0d, expected %0d",
                                    mean_velocity_o, want.avg_speed));
        if (accepted_count_o !== want.accepted_count)
          report_mismatch($sformatf("accepted_count %0d, expected %0d",
                                    accepted_count_o, want.accepted_count));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    overflow_o, want.overflow));
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("thresholded_force_speed_mean_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no idling: threshold edges, field extremes and the
    // run ends that matter most.
    begin_phase(0, 0);
    // A run with nothing accepted reports zero means.
    enqueue_sample(path_point(0, 0, 0, 0, 0, 0, 1));
    // A force exactly at the threshold is not accepted, on one axis or two.
    enqueue_sample(path_point(1000, 0, 0, 10000, 0, 0, 0));
    enqueue_sample(path_point(0, 0, 0, 6000, 8000, 0, 0));
    // Just above it: magnitude truncates to the threshold, distance is 5.
    enqueue_sample(path_point(3, 4, 0, 6000, 8000, 1, 0));
    enqueue_sample(path_point(POS_MAX, POS_MAX, POS_MAX, -10001, 0, 0, 0));
    // Full-scale negative position and force, then positive force extremes.
    enqueue_sample(path_point(POS_MIN, POS_MIN, POS_MIN,
                              POS_MIN, POS_MIN, POS_MIN, 0));
    enqueue_sample(path_point(POS_MAX, POS_MIN, 0,
                              POS_MAX, POS_MAX, POS_MAX, 1));
    // Single accepted sample forms a whole run.
    enqueue_sample(path_point(5, 5, 5, 20000, 0, 0, 1));
    // A run whose last sample falls below the threshold.
    enqueue_sample(path_point(-700, 300, 90, 0, -50000, 0, 0));
    enqueue_sample(path_point(900, 900, 900, 100, 0, 0, 1));
    drain();

    // Threshold zero and a zero period, which counts as one microsecond.
    write_reg(REG_FORCE_THRESHOLD, '0);
    write_reg(REG_SAMPLE_PERIOD, '0);
    begin_phase(66, 0);
    enqueue_sample(path_point(1, 2, 3, 0, 0, 0, 1));
    // Huge distance over a tiny period saturates the speed.
    enqueue_sample(path_point(POS_MAX, POS_MAX, POS_MAX, 1, 0, 0, 0));
    enqueue_sample(path_point(POS_MIN, POS_MIN, POS_MIN, 0, 0, -1, 1));
    // No movement at all gives zero speed.
    enqueue_sample(path_point(0, 0, 0, 0, 1, 0, 1));
    queue_random_runs(140);
    drain();

    // Highest threshold lets nothing through; longest legal period.
    write_reg(REG_FORCE_THRESHOLD, 24'hFFFFFF);
    write_reg(REG_SAMPLE_PERIOD, 24'd1000000);
    begin_phase(0, 66);
    queue_random_runs(40);
    drain();

    // Random threshold in the lower half, one microsecond period, both sides idle.
    write_reg(REG_FORCE_THRESHOLD, $urandom_range(0, 24'h7FFFFF));
    write_reg(REG_SAMPLE_PERIOD, 24'd1);
    begin_phase(30, 30);
    queue_random_runs(150);
    drain();

    // Back to the reset values while the receiver holds off for a long time.
    write_reg(REG_FORCE_THRESHOLD, THRESH_RST);
    write_reg(REG_SAMPLE_PERIOD, PERIOD_RST);
    begin_phase(0, 0);
    hold_req = 1'b1;
    queue_random_runs(60);
    drain();

    // Widest period field value and a random low threshold.
    write_reg(REG_FORCE_THRESHOLD, $urandom_range(0, 24'h3FFFFF));
    write_reg(REG_SAMPLE_PERIOD, 24'hFFFFF);
    begin_phase(0, 0);
    queue_random_runs(80);
    drain();

    // Random period within the legal range.
    write_reg(REG_SAMPLE_PERIOD, $urandom_range(1, 1000000));
    begin_phase(30, 30);
    queue_random_runs(120);
    drain();

    if (mismatch_count == 0) begin
      $display("thresholded_force_speed_mean_tb passed");
    end else begin
      $display("thresholded_force_speed_mean_tb failed");
    end
    $finish;
  end

endmodule

// ===== thresholded_force_speed_mean.f =====
src/tfsm_pkg.sv
src/tfsm_sqsum.sv
src/tfsm_sqrt.sv
src/tfsm_mul.sv
src/tfsm_div.sv
src/thresholded_force_speed_mean.sv
tb/sv/thresholded_force_speed_mean_tb.sv
